[sv/icph_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icph_pkg
// shared constants, codes and the end-around-carry adder for the
// pseudo-header checksum core
// ----------------------------------------------------------------------------
package icph_pkg;

    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] ADDR_BYTES = COUNT_BITS'(8);

    localparam logic [15:0] PROTO_UDP = 16'd17;
    localparam logic [15:0] PROTO_TCP = 16'd6;
    localparam logic [15:0] WORD_MASK = 16'hFFFF;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_UDP   = 2'd1;
    localparam logic [1:0] MODE_TCP   = 2'd2;

    typedef logic [COUNT_BITS-1:0] count_t;

    // ones' complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, acc} + {1'b0, word};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f[15:0];
    endfunction

endpackage

[sv/internet_checksum_pseudo_header_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// internet_checksum_pseudo_header_core
// streaming ones' complement checksum over a byte region with optional
// udp/tcp pseudo-header length and protocol terms
// ----------------------------------------------------------------------------
// channel   dir  tdata                  tuser                    tlast
// s_axis    in   [7:0] data_byte        [0] first_byte,          last_byte
//                                       [2:1] mode
// m_axis    out  [15:0] checksum_value  [0] short_region         -
//
// one byte word per cycle unless a stalled result holds input back; after its
// last byte is accepted, a result passes the input and then the result register
// the per-byte update is one end-around add between the input register and
// the running state; the result step adds up to two more for the pseudo-header
// rst_n clears the pipeline valids and the running state
// a stalled result only holds back input once a second last byte is waiting
// ----------------------------------------------------------------------------
module internet_checksum_pseudo_header_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    input  logic [2:0]  s_axis_tuser,   // [0] first_byte, [2:1] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] checksum_value
    output logic        m_axis_tuser    // [0] short_region
);

    // input register
    logic        in_valid_reg;
    logic [7:0]  data_reg;
    logic        first_reg;
    logic        last_reg;
    logic [1:0]  mode_reg;

    // running state
    logic [15:0]           sum_reg;
    logic [15:0]           sum_next;
    logic [7:0]            held_reg;
    logic [7:0]            held_next;
    logic                  phase_reg;
    logic                  phase_next;
    icph_pkg::count_t      count_reg;
    icph_pkg::count_t      count_next;
    logic [1:0]            hmode_reg;
    logic [1:0]            hmode_next;

    // result register
    logic        out_valid_reg;
    logic [15:0] checksum_reg;
    logic [15:0] checksum_next;
    logic        short_reg;
    logic        short_next;

    logic advance;
    logic in_accept;

    logic [15:0]      sum_base;
    logic             phase_base;
    icph_pkg::count_t cnt_base;
    icph_pkg::count_t cnt;
    logic [15:0]      sum_data;
    logic [15:0]      proto_word;
    logic [15:0]      len_word;
    logic [15:0]      sum_final;
    logic             pseudo;

    assign advance       = in_valid_reg && (!last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        sum_base   = first_reg ? 16'd0 : sum_reg;
        phase_base = first_reg ? 1'b0 : phase_reg;
        cnt_base   = first_reg ? '0 : count_reg;
        hmode_next = first_reg ? mode_reg : hmode_reg;

        cnt = (cnt_base == icph_pkg::COUNT_MAX) ? cnt_base : cnt_base + 1'b1;

        held_next = held_reg;
        if (phase_base)
        begin
            sum_data   = icph_pkg::oc_add(sum_base, {held_reg, data_reg});
            phase_next = 1'b0;
        end
        else
        begin
            // pad an odd final byte with a zero low byte
            sum_data   = last_reg ? icph_pkg::oc_add(sum_base, {data_reg, 8'h00}) : sum_base;
            held_next  = data_reg;
            phase_next = 1'b1;
        end

        pseudo     = (hmode_next == icph_pkg::MODE_UDP) || (hmode_next == icph_pkg::MODE_TCP);
        proto_word = (hmode_next == icph_pkg::MODE_UDP) ? icph_pkg::PROTO_UDP
                                                        : icph_pkg::PROTO_TCP;
        len_word   = 16'(cnt) - 16'(icph_pkg::ADDR_BYTES);
        sum_final  = pseudo ? icph_pkg::oc_add(icph_pkg::oc_add(sum_data, proto_word), len_word)
                            : sum_data;

        checksum_next = sum_final ^ icph_pkg::WORD_MASK;
        short_next    = pseudo && (cnt < icph_pkg::ADDR_BYTES);

        sum_next   = sum_data;
        count_next = cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            data_reg  <= s_axis_tdata;
            first_reg <= s_axis_tuser[0];
            last_reg  <= s_axis_tlast;
            mode_reg  <= s_axis_tuser[2:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            held_reg  <= '0;
            phase_reg <= 1'b0;
            count_reg <= '0;
            hmode_reg <= icph_pkg::MODE_PLAIN;
        end
        else if (advance)
        begin
            hmode_reg <= hmode_next;
            if (last_reg)
            begin
                sum_reg   <= '0;
                held_reg  <= '0;
                phase_reg <= 1'b0;
                count_reg <= '0;
            end
            else
            begin
                sum_reg   <= sum_next;
                held_reg  <= held_next;
                phase_reg <= phase_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            checksum_reg <= checksum_next;
            short_reg    <= short_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = checksum_reg;
    assign m_axis_tuser  = short_reg;

endmodule

[sv/icph_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icph_checker
// port-level checks for the pseudo-header checksum core
// ----------------------------------------------------------------------------
module icph_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // offered input word holds while stalled
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast)
            && $stable(s_axis_tuser))
        else $error("input word changed while stalled");

    // input only stalls behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // a new result only appears if the input side was ready on the clock edge that registered it
    a_rise_ready: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tready))
        else $error("result appeared while input was stalled");

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

endmodule

bind internet_checksum_pseudo_header_core icph_checker u_icph_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
